// File: rtl/fshx_pkg.sv
// Shared types and constants of the frame sync header/footer/XOR block.
`timescale 1ns / 1ps

package fshx_pkg;

   localparam int BYTE_W      = 8;
   localparam int PAT_W       = 64;
   localparam int PAT_IDX_W   = 3;
   localparam int MAX_RESULTS = 64;
   localparam int CSR_DATA_W  = 64;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_FRAME_LENGTH   = 3'd0,
      REG_HEADER_LENGTH  = 3'd1,
      REG_HEADER_PATTERN = 3'd2,
      REG_FOOTER_OFFSET  = 3'd3,
      REG_FOOTER_LENGTH  = 3'd4,
      REG_FOOTER_PATTERN = 3'd5,
      REG_CHECK_XOR      = 3'd6,
      REG_PAYLOAD_LENGTH = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_SCAN   = 2'b01,
      ST_ROTATE = 2'b10
   } state_type;

   // pattern settings broadcast to every cell (lengths already clamped)
   typedef struct packed {
      logic [3:0]       hdr_len;
      logic [PAT_W-1:0] hdr_pattern;
      logic [5:0]       ftr_offset;
      logic [3:0]       ftr_len;
      logic [PAT_W-1:0] ftr_pattern;
   } match_cfg_type;

   // per-cell test results
   typedef struct packed {
      logic in_frame;
      logic hdr_bad;
      logic ftr_bad;
   } cell_flags_type;

endpackage

// File: rtl/frame_sync_header_footer_xor.sv
// Top level: byte window as a chain of cells, match detection and payload emission.
//
//   channel | handshake            | contents
//   req     | req_tvalid/tready    | tdata: data_byte; tuser: action (1 = clear)
//   rsp     | rsp_tvalid/tready    | tdata: payload_byte; tlast: last_byte
//   csr     | csr_we               | csr_index selects register, csr_wdata value
//
// One byte per cycle is accepted while no frame matches. A matching frame is
// found in the cycle after its last byte; the chain then rotates once around
// all WINDOW_DEPTH cells, pausing while rsp is stalled, reading payload bytes
// at cell 0, and input is held off during that rotation.
// Reset is synchronous and active high; window bytes are not cleared.
`timescale 1ns / 1ps

module frame_sync_header_footer_xor #(
   parameter int WINDOW_DEPTH  = 64,
   parameter int PATTERN_BYTES = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [7:0] data_byte
   input  logic                    req_tuser,   // [0] action
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,   // [7:0] payload_byte
   output logic                    rsp_tlast,
   input  logic                    csr_we,
   input  fshx_pkg::reg_index_type csr_index,
   input  logic [63:0]             csr_wdata
);
   import fshx_pkg::*;

   localparam int PW  = $clog2(WINDOW_DEPTH);
   localparam int FW  = $clog2(WINDOW_DEPTH + 1);
   localparam int AW  = ((PW + 1 > 7) ? PW + 1 : 7) + 1;

   // configuration registers
   logic [6:0]       frame_length_ff;
   logic [3:0]       header_length_ff;
   logic [PAT_W-1:0] header_pattern_ff;
   logic [5:0]       footer_offset_ff;
   logic [3:0]       footer_length_ff;
   logic [PAT_W-1:0] footer_pattern_ff;
   logic             check_xor_ff;
   logic [6:0]       payload_length_ff;

   state_type        state_ff, state_in;
   logic [PW-1:0]    rot_ff, rot_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    start_ff, start_in;
   logic [AW-1:0]    end_ff, end_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [7:0]       cell_byte [WINDOW_DEPTH];
   cell_flags_type   cell_flags [WINDOW_DEPTH];
   match_cfg_type    mcfg;
   logic [3:0]       hl_c;
   logic [3:0]       fl_c;
   logic [AW-1:0]    len_w;
   logic [AW-1:0]    hl_w;
   logic [AW-1:0]    avail;
   logic [AW-1:0]    cnt;
   logic [AW-1:0]    rot_w;
   logic [7:0]       frame_xor;
   logic             any_hdr_bad;
   logic             any_ftr_bad;
   logic             hit;
   logic             push_acc;
   logic             clear_acc;
   logic             emit_now;
   logic             step;
   logic             shift_en;
   logic [7:0]       chain_in;

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff   <= 7'd8;
         header_length_ff  <= '0;
         header_pattern_ff <= '0;
         footer_offset_ff  <= '0;
         footer_length_ff  <= '0;
         footer_pattern_ff <= '0;
         check_xor_ff      <= 1'b0;
         payload_length_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_LENGTH:   frame_length_ff   <= csr_wdata[6:0];
            REG_HEADER_LENGTH:  header_length_ff  <= csr_wdata[3:0];
            REG_HEADER_PATTERN: header_pattern_ff <= csr_wdata;
            REG_FOOTER_OFFSET:  footer_offset_ff  <= csr_wdata[5:0];
            REG_FOOTER_LENGTH:  footer_length_ff  <= csr_wdata[3:0];
            REG_FOOTER_PATTERN: footer_pattern_ff <= csr_wdata;
            REG_CHECK_XOR:      check_xor_ff      <= csr_wdata[0];
            REG_PAYLOAD_LENGTH: payload_length_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // saturate pattern lengths to the pattern storage
   assign hl_c = (header_length_ff > 4'(PATTERN_BYTES)) ? 4'(PATTERN_BYTES) : header_length_ff;
   assign fl_c = (footer_length_ff > 4'(PATTERN_BYTES)) ? 4'(PATTERN_BYTES) : footer_length_ff;

   assign mcfg.hdr_len     = hl_c;
   assign mcfg.hdr_pattern = header_pattern_ff;
   assign mcfg.ftr_offset  = footer_offset_ff;
   assign mcfg.ftr_len     = fl_c;
   assign mcfg.ftr_pattern = footer_pattern_ff;

   assign len_w = AW'(frame_length_ff);
   assign hl_w  = AW'(hl_c);

   // ---------------- cell chain ----------------
   assign push_acc  = req_tvalid && req_tready && !req_tuser;
   assign clear_acc = req_tvalid && req_tready && req_tuser;
   assign rot_w     = AW'(rot_ff);
   assign emit_now  = (state_ff == ST_ROTATE) && (rot_w >= start_ff) && (rot_w < end_ff);
   assign step      = (state_ff == ST_ROTATE) && (!emit_now || !rsp_valid_ff || rsp_tready);
   assign shift_en  = push_acc || step;
   // rotate the oldest byte back in at the top, or take the new beat
   assign chain_in  = (state_ff == ST_ROTATE) ? cell_byte[0] : req_tdata;

   for (genvar p = 0; p < WINDOW_DEPTH; p++) begin : g_cell
      logic [7:0] nb;
      if (p == WINDOW_DEPTH - 1) begin : g_top
         assign nb = chain_in;
      end else begin : g_mid
         assign nb = cell_byte[p+1];
      end
      fshx_cell #(
         .POS          (p),
         .WINDOW_DEPTH (WINDOW_DEPTH),
         .AW           (AW)
      ) u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .shift_in  (nb),
         .frame_len (len_w),
         .cfg       (mcfg),
         .byte_out  (cell_byte[p]),
         .flags     (cell_flags[p])
      );
   end

   // ---------------- match detection ----------------
   always_comb begin
      frame_xor   = '0;
      any_hdr_bad = 1'b0;
      any_ftr_bad = 1'b0;
      for (int p = 0; p < WINDOW_DEPTH; p++) begin
         frame_xor   = frame_xor ^ (cell_byte[p] & {8{cell_flags[p].in_frame}});
         any_hdr_bad = any_hdr_bad | cell_flags[p].hdr_bad;
         any_ftr_bad = any_ftr_bad | cell_flags[p].ftr_bad;
      end
   end

   always_comb begin
      avail = len_w - hl_w;
      cnt   = (AW'(payload_length_ff) < avail) ? AW'(payload_length_ff) : avail;
      if (cnt > AW'(MAX_RESULTS)) begin
         cnt = AW'(MAX_RESULTS);
      end
      if (hl_w >= len_w) begin
         cnt = '0;
      end
   end

   assign hit = pend_ff
             && (frame_length_ff != 7'd0)
             && (len_w <= AW'(WINDOW_DEPTH))
             && (AW'(fill_ff) >= len_w)
             && (hl_w <= len_w)
             && ((fl_c == 4'd0) || (AW'(footer_offset_ff) + AW'(fl_c) <= len_w))
             && !any_hdr_bad && !any_ftr_bad
             && (!check_xor_ff || (frame_xor == 8'd0))
             && (cnt != '0);

   assign req_tready = (state_ff == ST_SCAN) && !hit;

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      rot_in   = rot_ff;
      fill_in  = fill_ff;
      pend_in  = push_acc;
      start_in = start_ff;
      end_in   = end_ff;
      if (clear_acc) begin
         fill_in = '0;
      end else if (push_acc && (fill_ff != FW'(WINDOW_DEPTH))) begin
         fill_in = fill_ff + 1'b1;
      end
      unique case (state_ff)
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_ROTATE;
               rot_in   = '0;
               start_in = AW'(WINDOW_DEPTH) - len_w + hl_w;
               end_in   = AW'(WINDOW_DEPTH) - len_w + hl_w + cnt;
            end
         end
         ST_ROTATE: begin
            if (step) begin
               if (rot_ff == PW'(WINDOW_DEPTH - 1)) begin
                  state_in = ST_SCAN;
                  rot_in   = '0;
               end else begin
                  rot_in = rot_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_SCAN;
            rot_in   = '0;
         end
      endcase
   end

   // output register: load on an emitting step, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (step && emit_now) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cell_byte[0];
         rsp_last_in  = (rot_w + 1'b1) == end_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SCAN;
         rot_ff       <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      end_ff      <= end_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_rot_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rot_ff == '0))
      else $error("rotation counter moved outside rotation");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_ROTATE))
      else $error("result beat loaded outside rotation");

   a_hit_rot: assert property (@(posedge clock) disable iff (reset)
      hit |=> (state_ff == ST_ROTATE))
      else $error("match did not start emission");

   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      AW'(fill_ff) <= AW'(WINDOW_DEPTH))
      else $error("fill count past window depth");
`endif

endmodule

// File: rtl/fshx_cell.sv
// One window cell: holds a byte, shifts it to its neighbor and checks it against the patterns.
`timescale 1ns / 1ps

module fshx_cell #(
   parameter int POS          = 0,
   parameter int WINDOW_DEPTH = 64,
   parameter int AW           = 8
) (
   input  logic                   clock,
   input  logic                   shift_en,
   input  logic [7:0]             shift_in,
   input  logic [AW-1:0]          frame_len,
   input  fshx_pkg::match_cfg_type cfg,
   output logic [7:0]             byte_out,
   output fshx_pkg::cell_flags_type flags
);
   import fshx_pkg::*;

   logic [7:0]           byte_ff;
   logic [7:0]           byte_in;
   logic [AW-1:0]        base;
   logic [AW-1:0]        k;
   logic [AW-1:0]        fk;
   logic                 in_frame;
   logic                 in_hdr;
   logic                 in_ftr;
   logic [PAT_IDX_W-1:0] hidx;
   logic [PAT_IDX_W-1:0] fidx;
   logic [7:0]           hbyte;
   logic [7:0]           fbyte;

   assign byte_in = shift_en ? shift_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // k is this cell's byte position within the candidate frame
   always_comb begin
      base     = AW'(POS) + frame_len;
      in_frame = base >= AW'(WINDOW_DEPTH);
      k        = base - AW'(WINDOW_DEPTH);
      fk       = k - AW'(cfg.ftr_offset);
      in_hdr   = in_frame && (k < AW'(cfg.hdr_len));
      in_ftr   = in_frame && (k >= AW'(cfg.ftr_offset)) && (fk < AW'(cfg.ftr_len));
      hidx     = k[PAT_IDX_W-1:0];
      fidx     = fk[PAT_IDX_W-1:0];
      hbyte    = cfg.hdr_pattern[{hidx, 3'b000} +: 8];
      fbyte    = cfg.ftr_pattern[{fidx, 3'b000} +: 8];
   end

   assign byte_out       = byte_ff;
   assign flags.in_frame = in_frame;
   assign flags.hdr_bad  = in_hdr && (byte_ff != hbyte);
   assign flags.ftr_bad  = in_ftr && (byte_ff != fbyte);

endmodule

// File: bench/frame_sync_header_footer_xor_tb.sv
// Self-checking bench for the frame sync block: frame-shaped byte streams, random flow, payload checks.
`timescale 1ns / 1ps

module frame_sync_header_footer_xor_tb;
   import fshx_pkg::*;

   localparam int WINDOW_DEPTH  = 64;
   localparam int PATTERN_BYTES = 8;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } payload_beat_type;

   typedef struct {
      logic [6:0]  frame_len;
      logic [3:0]  hdr_len;
      logic [63:0] hdr_pat;
      logic [5:0]  ftr_off;
      logic [3:0]  ftr_len;
      logic [63:0] ftr_pat;
      logic        xor_en;
      logic [6:0]  pay_len;
   } frame_cfg_type;

   // Mirror of the sliding window and the frame tests; holds the payload still due.
   class frame_matcher;
      logic [7:0]       win [WINDOW_DEPTH];
      int unsigned      fill;
      frame_cfg_type    cfg;
      payload_beat_type payload_due [$];
      int               beats_in, clears, beats_out, runs, mismatches;

      function new();
         foreach (win[i]) win[i] = 8'h00;
         fill = 0;
         cfg.frame_len = 7'd8;
         cfg.hdr_len   = 4'd0;
         cfg.hdr_pat   = 64'd0;
         cfg.ftr_off   = 6'd0;
         cfg.ftr_len   = 4'd0;
         cfg.ftr_pat   = 64'd0;
         cfg.xor_en    = 1'b0;
         cfg.pay_len   = 7'd0;
      endfunction

      function void set_reg(reg_index_type r, logic [63:0] v);
         case (r)
            REG_FRAME_LENGTH:   cfg.frame_len = v[6:0];
            REG_HEADER_LENGTH:  cfg.hdr_len   = v[3:0];
            REG_HEADER_PATTERN: cfg.hdr_pat   = v;
            REG_FOOTER_OFFSET:  cfg.ftr_off   = v[5:0];
            REG_FOOTER_LENGTH:  cfg.ftr_len   = v[3:0];
            REG_FOOTER_PATTERN: cfg.ftr_pat   = v;
            REG_CHECK_XOR:      cfg.xor_en    = v[0];
            REG_PAYLOAD_LENGTH: cfg.pay_len   = v[6:0];
            default: ;
         endcase
      endfunction

      function int unsigned clamp_pat(logic [3:0] n);
         return (n > PATTERN_BYTES) ? PATTERN_BYTES : int'(n);
      endfunction

      // byte i of the frame made of the newest len bytes
      function logic [7:0] frame_byte(int unsigned len, int unsigned i);
         return win[WINDOW_DEPTH - len + i];
      endfunction

      function bit pattern_hit(int unsigned len, int unsigned start, int unsigned n,
                               logic [63:0] pat);
         if (n == 0) return 1'b1;
         if (start + n > len) return 1'b0;
         for (int i = 0; i < n; i++)
            if (frame_byte(len, start + i) != pat[8*i +: 8]) return 1'b0;
         return 1'b1;
      endfunction

      function void push_beat(logic clear, logic [7:0] b);
         int unsigned      len, hl, fl, cnt;
         logic [7:0]       acc;
         payload_beat_type beat;
         beats_in++;
         if (clear) begin
            clears++;
            foreach (win[i]) win[i] = 8'h00;
            fill = 0;
            return;
         end
         for (int i = 0; i < WINDOW_DEPTH - 1; i++) win[i] = win[i+1];
         win[WINDOW_DEPTH-1] = b;
         if (fill < WINDOW_DEPTH) fill++;
         len = int'(cfg.frame_len);
         hl  = clamp_pat(cfg.hdr_len);
         fl  = clamp_pat(cfg.ftr_len);
         if (len == 0 || len > WINDOW_DEPTH || fill < len) return;
         if (!pattern_hit(len, 0, hl, cfg.hdr_pat)) return;
         if (!pattern_hit(len, int'(cfg.ftr_off), fl, cfg.ftr_pat)) return;
         if (cfg.xor_en) begin
            acc = 8'h00;
            for (int i = 0; i < len; i++) acc ^= frame_byte(len, i);
            if (acc != 8'h00) return;
         end
         cnt = int'(cfg.pay_len);
         if (hl >= len) cnt = 0;
         else if (cnt > len - hl) cnt = len - hl;
         if (cnt > MAX_RESULTS) cnt = MAX_RESULTS;
         for (int i = 0; i < cnt; i++) begin
            beat.data = frame_byte(len, hl + i);
            beat.last = (i + 1 == cnt);
            payload_due.push_back(beat);
         end
      endfunction

      function void check_payload(logic [7:0] b, logic last);
         payload_beat_type want;
         beats_out++;
         if (last) runs++;
         if (payload_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected payload beat data=%02h last=%0b", $realtime, b, last);
            return;
         end
         want = payload_due.pop_front();
         if (want.data !== b || want.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: payload mismatch: expected data=%02h last=%0b, got data=%02h last=%0b",
                        $realtime, want.data, want.last, b, last);
         end
      endfunction
   endclass

   logic           clock;
   logic           reset;
   logic           req_tvalid;
   logic           req_tready;
   logic [7:0]     req_tdata;   // [7:0] data_byte
   logic           req_tuser;   // [0] action
   logic           rsp_tvalid;
   logic           rsp_tready;
   logic [7:0]     rsp_tdata;   // [7:0] payload_byte
   logic           rsp_tlast;
   logic           csr_we;
   reg_index_type  csr_index;
   logic [63:0]    csr_wdata;

   frame_matcher board;
   bit           steady_flow;
   int           rx_hold;
   int           settings;

   frame_sync_header_footer_xor #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .PATTERN_BYTES(PATTERN_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic frame_cfg_type make_cfg(int fl, int hl, int fo, int ftl, int x, int pl);
      frame_cfg_type c;
      c.frame_len = 7'(fl);
      c.hdr_len   = 4'(hl);
      c.hdr_pat   = {$urandom, $urandom};
      c.ftr_off   = 6'(fo);
      c.ftr_len   = 4'(ftl);
      c.ftr_pat   = {$urandom, $urandom};
      c.xor_en    = 1'(x);
      c.pay_len   = 7'(pl);
      return c;
   endfunction

   task automatic write_reg(reg_index_type r, logic [63:0] v);
      csr_we    <= 1'b1;
      csr_index <= r;
      csr_wdata <= v;
      @(posedge clock);
      board.set_reg(r, v);
   endtask

   task automatic write_config(frame_cfg_type c);
      write_reg(REG_FRAME_LENGTH,   64'(c.frame_len));
      write_reg(REG_HEADER_LENGTH,  64'(c.hdr_len));
      write_reg(REG_HEADER_PATTERN, c.hdr_pat);
      write_reg(REG_FOOTER_OFFSET,  64'(c.ftr_off));
      write_reg(REG_FOOTER_LENGTH,  64'(c.ftr_len));
      write_reg(REG_FOOTER_PATTERN, c.ftr_pat);
      write_reg(REG_CHECK_XOR,      64'(c.xor_en));
      write_reg(REG_PAYLOAD_LENGTH, 64'(c.pay_len));
      csr_we <= 1'b0;
      settings++;
   endtask

   task automatic send_item(logic clear, logic [7:0] b);
      int gap;
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= clear;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      board.push_beat(clear, b);
   endtask

   // drain payload, then let the last rotation run out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.payload_due.size() != 0) @(posedge clock);
      repeat (2 * WINDOW_DEPTH) @(posedge clock);
   endtask

   task automatic run_phase(frame_cfg_type c, int n_items, bit steady, int hold);
      logic [7:0]  fr [WINDOW_DEPTH];
      logic [7:0]  acc;
      int          sent, roll, len, hl, fl, fo, p;
      bit          fixed;
      wait_idle();
      write_config(c);
      steady_flow = steady;
      rx_hold     = hold;
      len = int'(c.frame_len);
      hl  = (c.hdr_len > PATTERN_BYTES) ? PATTERN_BYTES : int'(c.hdr_len);
      fl  = (c.ftr_len > PATTERN_BYTES) ? PATTERN_BYTES : int'(c.ftr_len);
      fo  = int'(c.ftr_off);
      sent = 0;
      while (sent < n_items) begin
         roll = $urandom_range(99);
         if (roll < 4) begin
            send_item(1'b1, 8'($urandom));
            sent++;
         end else if (roll < 14 || len == 0 || len > WINDOW_DEPTH || sent + len > n_items) begin
            send_item(1'b0, 8'($urandom));
            sent++;
         end else begin
            // build a frame that passes every enabled test, then maybe break it
            for (int i = 0; i < len; i++) fr[i] = 8'($urandom);
            for (int i = 0; i < hl && i < len; i++) fr[i] = c.hdr_pat[8*i +: 8];
            for (int i = 0; i < fl && fo + i < len; i++) fr[fo+i] = c.ftr_pat[8*i +: 8];
            if (c.xor_en) begin
               fixed = 1'b0;
               for (p = len - 1; p >= 0 && !fixed; p--) begin
                  if (p >= hl && !(p >= fo && p < fo + fl)) begin
                     acc = 8'h00;
                     for (int i = 0; i < len; i++) acc ^= fr[i];
                     fr[p] ^= acc;
                     fixed = 1'b1;
                  end
               end
            end
            if ($urandom_range(99) < 15) begin
               p = $urandom_range(len - 1);
               fr[p] ^= 8'(1 << $urandom_range(7));
            end
            for (int i = 0; i < len; i++) begin
               send_item(1'b0, fr[i]);
               sent++;
            end
         end
      end
   endtask

   // receiver flow control, with an occasional long hold-off on request
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      forever begin
         if (rx_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (rx_hold) @(posedge clock);
            rx_hold = 0;
         end else if (steady_flow) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_payload(rsp_tdata, rsp_tlast);
   end

   initial begin
      #50_000_000;
      $display("timeout: payload stream did not drain");
      $display("FAIL");
      $finish;
   end

   initial begin
      frame_cfg_type c;
      int            failures;
      board       = new();
      steady_flow = 1'b0;
      rx_hold     = 0;
      settings    = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= REG_FRAME_LENGTH;
      csr_wdata  <= 64'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: header 00 FF, footer 5A at byte 3, two payload bytes
      c = make_cfg(4, 2, 3, 1, 0, 2);
      c.hdr_pat = 64'h0000_0000_0000_FF00;
      c.ftr_pat = 64'h0000_0000_0000_005A;
      write_config(c);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'h12);
      send_item(1'b0, 8'h5A);
      send_item(1'b0, 8'h00);
      send_item(1'b1, 8'hFF);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'h80);
      send_item(1'b0, 8'h5A);
      send_item(1'b0, 8'h5A);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'h01);
      send_item(1'b0, 8'h7F);

      c = make_cfg(8, 2, 6, 2, 0, 4);
      c.hdr_pat = '1;
      c.ftr_pat = '0;
      run_phase(c, 36, 1'b0, 0);
      // full-window frame with XOR check; payload request is cut at the frame end
      run_phase(make_cfg(64, 0, 0, 0, 1, 127), 70, 1'b0, 0);
      // every byte matches: hold the receiver so the block backs up its input
      run_phase(make_cfg(1, 0, 0, 0, 0, 1), 25, 1'b0, 400);
      run_phase(make_cfg(0, 1, 0, 0, 0, 5), 8, 1'b0, 0);
      run_phase(make_cfg(127, 0, 0, 0, 0, 5), 8, 1'b0, 0);
      // header and footer lengths saturate to eight bytes each
      run_phase(make_cfg(16, 15, 8, 15, 0, 10), 34, 1'b0, 0);
      run_phase(make_cfg(10, 3, 63, 1, 1, 4), 10, 1'b0, 0);
      run_phase(make_cfg(4, 8, 0, 0, 0, 3), 8, 1'b0, 0);
      run_phase(make_cfg(3, 3, 0, 0, 0, 5), 12, 1'b0, 0);
      run_phase(make_cfg(5, 0, 0, 0, 0, 0), 10, 1'b0, 0);
      c = make_cfg(16, 1, 0, 8, 1, 64);
      c.ftr_pat[7:0] = c.hdr_pat[7:0];
      run_phase(c, 36, 1'b0, 0);
      run_phase(make_cfg(20, 4, 10, 3, 1, 12), 30, 1'b1, 0);
      steady_flow = 1'b0;
      wait_idle();

      failures = board.mismatches + board.payload_due.size();
      $display("Sent %0d input beats (%0d clears) across %0d register settings.",
               board.beats_in, board.clears, settings);
      $display("Checked %0d payload beats in %0d runs; %0d mismatches, %0d beats never arrived.",
               board.beats_out, board.runs, board.mismatches, board.payload_due.size());
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
